FILE: rtl/rtml_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Route table metric lookup: shared definitions
// Command and status codes, sequencer states and the route and result types.
// ----------------------------------------------------------------------------
package rtml_pkg;

  localparam int ADDR_W   = 32;
  localparam int PORT_W   = 4;
  localparam int COST_W   = 16;
  localparam int SLOT_W   = 4;
  localparam int CMD_W    = 2;
  localparam int STATUS_W = 3;

  typedef enum logic [CMD_W-1:0] {
    CMD_ADD    = 2'd0,
    CMD_DEL    = 2'd1,
    CMD_LOOKUP = 2'd2
  } cmd_e;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK      = 3'd0,
    STAT_DUP     = 3'd1,
    STAT_FULL    = 3'd2,
    STAT_MISSING = 3'd3,
    STAT_NOROUTE = 3'd4
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_UPDATE,
    S_WRITE,
    S_DONE
  } state_e;

  typedef struct packed {
    logic [ADDR_W-1:0] dest;
    logic [ADDR_W-1:0] mask;
    logic [PORT_W-1:0] port;
    logic [COST_W-1:0] cost;
  } route_t;

  typedef struct packed {
    status_e           status;
    logic              found;
    logic [PORT_W-1:0] out_iface;
    logic [COST_W-1:0] out_metric;
    logic [SLOT_W-1:0] slot;
  } result_t;

endpackage

FILE: rtl/rtml_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Route table metric lookup: channel interfaces
// Command channel into the table and result channel out of it.
// ----------------------------------------------------------------------------
interface rtml_req_if import rtml_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CMD_W-1:0]  cmd;
  logic [ADDR_W-1:0] addr;
  logic [ADDR_W-1:0] mask;
  logic [PORT_W-1:0] iface;
  logic [COST_W-1:0] metric;

  modport source (output valid, cmd, addr, mask, iface, metric, input ready);
  modport sink   (input valid, cmd, addr, mask, iface, metric, output ready);
endinterface

interface rtml_rsp_if import rtml_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic                found;
  logic [PORT_W-1:0]   out_iface;
  logic [COST_W-1:0]   out_metric;
  logic [SLOT_W-1:0]   slot;

  modport source (output valid, status, found, out_iface, out_metric, slot, input ready);
  modport sink   (input valid, status, found, out_iface, out_metric, slot, output ready);
endinterface

FILE: rtl/route_table_metric_lookup_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Route table metric lookup unit
// Route table with add, delete and lowest-metric lookup commands.
// ----------------------------------------------------------------------------
// Commands are handled one at a time. Every command streams all ENTRIES
// entries through the single read port of the entry memory in a scan pass;
// a successful delete adds a second pass to rewrite recency ranks, and a
// successful add adds that pass plus a write that stores the new route.
// The next command is accepted once the result has left the sequencer.
// The next command is accepted while a result still waits in the output
// register. Entry contents need no clearing after reset; only the per-entry
// valid flags are reset.
module route_table_metric_lookup_unit import rtml_pkg::*; #(
  parameter int ENTRIES = 16,
  parameter int PORTS   = 16
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  rtml_req_if.sink   req_i,
  rtml_rsp_if.source rsp_o
);

  localparam int IW = $clog2(ENTRIES);
  localparam int DW = $bits(route_t) + IW;

  logic          mem_wr_en;
  logic [IW-1:0] mem_wr_addr;
  logic [DW-1:0] mem_wr_data;
  logic          mem_rd_en;
  logic [IW-1:0] mem_rd_addr;
  logic [DW-1:0] mem_rd_data;
  logic          res_valid;
  logic          res_ready;
  result_t       res;
  logic          out_valid_q;
  result_t       out_q;

  rtml_mem #(
    .DEPTH (ENTRIES),
    .WIDTH (DW)
  ) u_mem (
    .clk_i     (clk_i),
    .wr_en_i   (mem_wr_en),
    .wr_addr_i (mem_wr_addr),
    .wr_data_i (mem_wr_data),
    .rd_en_i   (mem_rd_en),
    .rd_addr_i (mem_rd_addr),
    .rd_data_o (mem_rd_data)
  );

  rtml_ctrl #(
    .ENTRIES (ENTRIES),
    .PORTS   (PORTS)
  ) u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .req_i         (req_i),
    .mem_wr_en_o   (mem_wr_en),
    .mem_wr_addr_o (mem_wr_addr),
    .mem_wr_data_o (mem_wr_data),
    .mem_rd_en_o   (mem_rd_en),
    .mem_rd_addr_o (mem_rd_addr),
    .mem_rd_data_i (mem_rd_data),
    .res_valid_o   (res_valid),
    .res_ready_i   (res_ready),
    .res_o         (res)
  );

  // Output register: a new word loads when the old one is gone or leaving.
  assign res_ready = !out_valid_q || rsp_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid_q <= 1'b1;
    end else if (rsp_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && res_ready) begin
      out_q <= res;
    end
  end

  assign rsp_o.valid      = out_valid_q;
  assign rsp_o.status     = out_q.status;
  assign rsp_o.found      = out_q.found;
  assign rsp_o.out_iface  = out_q.out_iface;
  assign rsp_o.out_metric = out_q.out_metric;
  assign rsp_o.slot       = out_q.slot;

endmodule

FILE: rtl/rtml_mem.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Route table metric lookup: entry memory
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module rtml_mem #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 88,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             wr_en_i,
  input  logic [AW-1:0]    wr_addr_i,
  input  logic [WIDTH-1:0] wr_data_i,
  input  logic             rd_en_i,
  input  logic [AW-1:0]    rd_addr_i,
  output logic [WIDTH-1:0] rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

FILE: rtl/rtml_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Route table metric lookup: command sequencer
// Scans the entry memory for matches, free slots and the best route, then
// rewrites recency ranks and stores new routes.
// ----------------------------------------------------------------------------
module rtml_ctrl import rtml_pkg::*; #(
  parameter int ENTRIES = 16,
  parameter int PORTS   = 16,
  parameter int IW      = $clog2(ENTRIES),
  parameter int DW      = $bits(route_t) + IW
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  rtml_req_if.sink        req_i,
  output logic            mem_wr_en_o,
  output logic [IW-1:0]   mem_wr_addr_o,
  output logic [DW-1:0]   mem_wr_data_o,
  output logic            mem_rd_en_o,
  output logic [IW-1:0]   mem_rd_addr_o,
  input  logic [DW-1:0]   mem_rd_data_i,
  output logic            res_valid_o,
  input  logic            res_ready_i,
  output result_t         res_o
);

  localparam int CW       = $clog2(ENTRIES + 1);
  localparam int PORT_NUM = 1 << PORT_W;

  // Interface number folded into the configured port count.
  logic [PORT_W-1:0] port_fold [PORT_NUM];
  for (genvar g = 0; g < PORT_NUM; g++) begin : g_fold
    localparam int Folded = g % PORTS;
    assign port_fold[g] = PORT_W'(Folded);
  end

  state_e            state_q, state_d;
  logic [CW-1:0]     cnt_q, cnt_d;
  logic              pend_q, pend_d;
  logic [IW-1:0]     pend_idx_q, pend_idx_d;
  logic [ENTRIES-1:0] valid_q, valid_d;
  logic              hit_q, hit_d;
  logic              free_q, free_d;
  logic              best_q, best_d;

  logic [CMD_W-1:0]  cmd_q, cmd_d;
  route_t            key_q, key_d;
  logic [IW-1:0]     hit_idx_q, hit_idx_d;
  logic [IW-1:0]     hit_age_q, hit_age_d;
  logic [IW-1:0]     free_idx_q, free_idx_d;
  logic [IW-1:0]     best_idx_q, best_idx_d;
  logic [IW-1:0]     best_age_q, best_age_d;
  logic [COST_W-1:0] best_cost_q, best_cost_d;
  logic [PORT_W-1:0] best_port_q, best_port_d;
  result_t           res_q, res_d;

  route_t            rd_route;
  logic [IW-1:0]     rd_age;
  logic              rd_vld;
  logic              exact;
  logic              match;
  logic              issue;
  logic              pass_end;

  assign rd_route = route_t'(mem_rd_data_i[DW-1:IW]);
  assign rd_age   = mem_rd_data_i[IW-1:0];
  assign rd_vld   = valid_q[pend_idx_q];
  assign exact    = rd_vld && rd_route.dest == key_q.dest &&
                    rd_route.mask == key_q.mask && rd_route.port == key_q.port;
  assign match    = rd_vld && ((key_q.dest & rd_route.mask) == rd_route.dest);
  assign issue    = cnt_q < CW'(ENTRIES);
  assign pass_end = !issue && !pend_q;

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    pend_d      = 1'b0;
    pend_idx_d  = pend_idx_q;
    valid_d     = valid_q;
    hit_d       = hit_q;
    free_d      = free_q;
    best_d      = best_q;
    cmd_d       = cmd_q;
    key_d       = key_q;
    hit_idx_d   = hit_idx_q;
    hit_age_d   = hit_age_q;
    free_idx_d  = free_idx_q;
    best_idx_d  = best_idx_q;
    best_age_d  = best_age_q;
    best_cost_d = best_cost_q;
    best_port_d = best_port_q;
    res_d       = res_q;

    req_i.ready   = 1'b0;
    res_valid_o   = 1'b0;
    mem_rd_en_o   = 1'b0;
    mem_rd_addr_o = cnt_q[IW-1:0];
    mem_wr_en_o   = 1'b0;
    mem_wr_addr_o = pend_idx_q;
    mem_wr_data_o = {rd_route, rd_age};

    // Both passes stream the memory: one read issued per cycle, the data of
    // the previous read handled in the same cycle.
    if (state_q == S_SCAN || state_q == S_UPDATE) begin
      if (issue) begin
        mem_rd_en_o = 1'b1;
        cnt_d       = cnt_q + CW'(1);
        pend_d      = 1'b1;
        pend_idx_d  = cnt_q[IW-1:0];
      end
    end

    case (state_q)
      S_IDLE: begin
        req_i.ready = 1'b1;
        if (req_i.valid) begin
          cmd_d       = req_i.cmd;
          key_d.dest  = req_i.addr;
          key_d.mask  = req_i.mask;
          key_d.port  = port_fold[req_i.iface];
          key_d.cost  = req_i.metric;
          hit_d       = 1'b0;
          free_d      = 1'b0;
          best_d      = 1'b0;
          cnt_d       = '0;
          state_d     = S_SCAN;
        end
      end

      S_SCAN: begin
        if (pend_q) begin
          if (exact && !hit_q) begin
            hit_d     = 1'b1;
            hit_idx_d = pend_idx_q;
            hit_age_d = rd_age;
          end
          if (!rd_vld && !free_q) begin
            free_d     = 1'b1;
            free_idx_d = pend_idx_q;
          end
          // Lower metric wins; on equal metric the newer entry (lower rank).
          if (match && (!best_q || rd_route.cost < best_cost_q ||
              (rd_route.cost == best_cost_q && rd_age < best_age_q))) begin
            best_d      = 1'b1;
            best_idx_d  = pend_idx_q;
            best_age_d  = rd_age;
            best_cost_d = rd_route.cost;
            best_port_d = rd_route.port;
          end
        end
        if (pass_end) begin
          res_d   = '{status: STAT_OK, found: 1'b0, out_iface: '0,
                      out_metric: '0, slot: '0};
          cnt_d   = '0;
          state_d = S_DONE;
          case (cmd_q)
            CMD_ADD: begin
              if (hit_q) begin
                res_d.status = STAT_DUP;
                res_d.slot   = SLOT_W'(hit_idx_q);
              end else if (!free_q) begin
                res_d.status = STAT_FULL;
              end else begin
                res_d.slot = SLOT_W'(free_idx_q);
                state_d    = S_UPDATE;
              end
            end
            CMD_DEL: begin
              if (!hit_q) begin
                res_d.status = STAT_MISSING;
              end else begin
                res_d.slot          = SLOT_W'(hit_idx_q);
                valid_d[hit_idx_q]  = 1'b0;
                state_d             = S_UPDATE;
              end
            end
            CMD_LOOKUP: begin
              if (best_q) begin
                res_d.found      = 1'b1;
                res_d.out_iface  = best_port_q;
                res_d.out_metric = best_cost_q;
                res_d.slot       = SLOT_W'(best_idx_q);
              end else begin
                res_d.status = STAT_NOROUTE;
              end
            end
            default: begin
            end
          endcase
        end
      end

      // Writes go to the entry whose read was issued in the previous cycle while the next entry is
      // read, so a pass never reads an entry it has not finished writing.
      S_UPDATE: begin
        if (pend_q && rd_vld) begin
          if (cmd_q == CMD_ADD) begin
            mem_wr_en_o   = 1'b1;
            mem_wr_data_o = {rd_route, rd_age + IW'(1)};
          end else if (rd_age > hit_age_q) begin
            mem_wr_en_o   = 1'b1;
            mem_wr_data_o = {rd_route, rd_age - IW'(1)};
          end
        end
        if (pass_end) begin
          state_d = (cmd_q == CMD_ADD) ? S_WRITE : S_DONE;
        end
      end

      S_WRITE: begin
        mem_wr_en_o         = 1'b1;
        mem_wr_addr_o       = free_idx_q;
        mem_wr_data_o       = {key_q, IW'(0)};
        valid_d[free_idx_q] = 1'b1;
        state_d             = S_DONE;
      end

      S_DONE: begin
        res_valid_o = 1'b1;
        if (res_ready_i) begin
          state_d = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
      pend_q  <= 1'b0;
      valid_q <= '0;
      hit_q   <= 1'b0;
      free_q  <= 1'b0;
      best_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      pend_q  <= pend_d;
      valid_q <= valid_d;
      hit_q   <= hit_d;
      free_q  <= free_d;
      best_q  <= best_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pend_idx_q  <= pend_idx_d;
    cmd_q       <= cmd_d;
    key_q       <= key_d;
    hit_idx_q   <= hit_idx_d;
    hit_age_q   <= hit_age_d;
    free_idx_q  <= free_idx_d;
    best_idx_q  <= best_idx_d;
    best_age_q  <= best_age_d;
    best_cost_q <= best_cost_d;
    best_port_q <= best_port_d;
    res_q       <= res_d;
  end

  assign res_o = res_q;

endmodule

FILE: sim/route_table_metric_lookup_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Route table metric lookup unit: testbench
// Drives add, delete and lookup commands and checks every result word against
// a behavioral route table kept by a small scoreboard class. A directed part
// covers empty and full tables, duplicates, ties and the unused command code.
// The random part keeps the table busy under varying sender and receiver
// idling.
// ----------------------------------------------------------------------------
module route_table_metric_lookup_unit_tb;
  import rtml_pkg::*;

  localparam int ENTRIES        = 16;
  localparam int PORTS          = 16;
  localparam int STALL_LIMIT    = 2000;
  localparam int PHASE_COMMANDS = 312;
  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

  class route_scoreboard;
    bit          in_use [ENTRIES];
    route_t      routes [ENTRIES];
    int unsigned rank   [ENTRIES];
    result_t     expected_q [$];
    int errors;
    int results_seen;
    int adds, dups, fulls, deletes, del_misses, hits, misses, unused;

    function int find_route(logic [ADDR_W-1:0] dest, logic [ADDR_W-1:0] mask,
                            logic [PORT_W-1:0] port);
      for (int i = 0; i < ENTRIES; i++) begin
        if (in_use[i] && routes[i].dest == dest && routes[i].mask == mask &&
            routes[i].port == port) return i;
      end
      return -1;
    endfunction

    function int route_count();
      int n;
      n = 0;
      for (int i = 0; i < ENTRIES; i++) n += in_use[i];
      return n;
    endfunction

    // Returns a random occupied entry, or -1 on an empty table.
    function int any_route();
      int idx [$];
      for (int i = 0; i < ENTRIES; i++) if (in_use[i]) idx.push_back(i);
      if (idx.size() == 0) return -1;
      return idx[$urandom_range(idx.size() - 1)];
    endfunction

    function void note_command(logic [CMD_W-1:0] cmd, logic [ADDR_W-1:0] addr,
                               logic [ADDR_W-1:0] mask, logic [PORT_W-1:0] iface,
                               logic [COST_W-1:0] metric);
      result_t           exp;
      logic [PORT_W-1:0] port;
      int                hit, free_slot, best;
      int unsigned       gone;
      exp  = '0;
      port = PORT_W'(int'(iface) % PORTS);
      case (cmd)
        CMD_ADD: begin
          hit = find_route(addr, mask, port);
          if (hit >= 0) begin
            exp.status = STAT_DUP;
            exp.slot   = SLOT_W'(hit);
            dups++;
          end else begin
            free_slot = -1;
            for (int i = 0; i < ENTRIES; i++)
              if (!in_use[i] && free_slot < 0) free_slot = i;
            if (free_slot < 0) begin
              exp.status = STAT_FULL;
              fulls++;
            end else begin
              for (int i = 0; i < ENTRIES; i++) if (in_use[i]) rank[i]++;
              in_use[free_slot] = 1'b1;
              routes[free_slot] = '{dest: addr, mask: mask, port: port, cost: metric};
              rank[free_slot]   = 0;
              exp.status = STAT_OK;
              exp.slot   = SLOT_W'(free_slot);
              adds++;
            end
          end
        end
        CMD_DEL: begin
          hit = find_route(addr, mask, port);
          if (hit < 0) begin
            exp.status = STAT_MISSING;
            del_misses++;
          end else begin
            gone        = rank[hit];
            in_use[hit] = 1'b0;
            for (int i = 0; i < ENTRIES; i++)
              if (in_use[i] && rank[i] > gone) rank[i]--;
            exp.status = STAT_OK;
            exp.slot   = SLOT_W'(hit);
            deletes++;
          end
        end
        CMD_LOOKUP: begin
          best = -1;
          for (int i = 0; i < ENTRIES; i++) begin
            if (in_use[i] && (addr & routes[i].mask) == routes[i].dest) begin
              if (best < 0 || routes[i].cost < routes[best].cost ||
                  (routes[i].cost == routes[best].cost && rank[i] < rank[best]))
                best = i;
            end
          end
          if (best < 0) begin
            exp.status = STAT_NOROUTE;
            misses++;
          end else begin
            exp.status     = STAT_OK;
            exp.found      = 1'b1;
            exp.out_iface  = routes[best].port;
            exp.out_metric = routes[best].cost;
            exp.slot       = SLOT_W'(best);
            hits++;
          end
        end
        default: begin
          exp.status = STAT_OK;
          unused++;
        end
      endcase
      expected_q.push_back(exp);
    endfunction

    task report(string msg);
      errors++;
      if (errors <= 30) $display("ERROR @%0t: %s", $time, msg);
    endtask

    task check_result(result_t got);
      result_t exp;
      results_seen++;
      if (expected_q.size() == 0) begin
        report($sformatf("result word with no command pending (status %0d slot %0d)",
                         got.status, got.slot));
        return;
      end
      exp = expected_q.pop_front();
      if (got.status !== exp.status)
        report($sformatf("status %0d, expected %0d", got.status, exp.status));
      if (got.found !== exp.found)
        report($sformatf("found %0b, expected %0b", got.found, exp.found));
      if (got.out_iface !== exp.out_iface)
        report($sformatf("out_iface %0d, expected %0d", got.out_iface, exp.out_iface));
      if (got.out_metric !== exp.out_metric)
        report($sformatf("out_metric %0d, expected %0d", got.out_metric, exp.out_metric));
      if (got.slot !== exp.slot)
        report($sformatf("slot %0d, expected %0d", got.slot, exp.slot));
    endtask
  endclass

  logic clk_i = 1'b0;
  logic rst_ni;

  rtml_req_if req_if ();
  rtml_rsp_if rsp_if ();

  route_table_metric_lookup_unit #(
    .ENTRIES(ENTRIES),
    .PORTS  (PORTS)
  ) u_top (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (req_if),
    .rsp_o (rsp_if)
  );

  route_scoreboard sb;
  int send_idle_pct;
  int recv_stall_pct;
  int hold_cycles;
  int commands_sent;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  initial begin
    sb             = new;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_cycles    = 0;
    commands_sent  = 0;
    rst_ni         = 1'b0;
    req_if.valid   = 1'b0;
    req_if.cmd     = '0;
    req_if.addr    = '0;
    req_if.mask    = '0;
    req_if.iface   = '0;
    req_if.metric  = '0;
    rsp_if.ready   = 1'b0;
  end

  // Result side: a long hold-off takes precedence over the random stalls.
  always @(negedge clk_i) begin
    if (hold_cycles > 0) begin
      rsp_if.ready = 1'b0;
      hold_cycles--;
    end else begin
      rsp_if.ready = ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk_i) begin : result_check
    result_t got;
    if (rst_ni && rsp_if.valid && rsp_if.ready) begin
      got.status     = status_e'(rsp_if.status);
      got.found      = rsp_if.found;
      got.out_iface  = rsp_if.out_iface;
      got.out_metric = rsp_if.out_metric;
      got.slot       = rsp_if.slot;
      sb.check_result(got);
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    @(posedge rst_ni);
    while (quiet < STALL_LIMIT) begin
      @(posedge clk_i);
      if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) quiet = 0;
      else quiet++;
    end
    $display("Timeout: no word moved for %0d cycles", STALL_LIMIT);
    $display("TEST FAILED");
    $finish;
  end

  task automatic send_cmd(logic [CMD_W-1:0] cmd, logic [ADDR_W-1:0] addr,
                          logic [ADDR_W-1:0] mask, logic [PORT_W-1:0] iface,
                          logic [COST_W-1:0] metric);
    @(negedge clk_i);
    while ($urandom_range(99) < send_idle_pct) begin
      req_if.valid = 1'b0;
      @(negedge clk_i);
    end
    req_if.valid  = 1'b1;
    req_if.cmd    = cmd;
    req_if.addr   = addr;
    req_if.mask   = mask;
    req_if.iface  = iface;
    req_if.metric = metric;
    @(posedge clk_i);
    while (!req_if.ready) @(posedge clk_i);
    sb.note_command(cmd, addr, mask, iface, metric);
    commands_sent++;
  endtask

  // Stops offering and waits until every pending result word has arrived.
  task automatic drain_results();
    @(negedge clk_i);
    req_if.valid = 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk_i);
  endtask

  function automatic logic [ADDR_W-1:0] random_mask();
    int len;
    if ($urandom_range(99) < 25) return $urandom;
    case ($urandom_range(5))
      0:       len = 0;
      1:       len = 8;
      2:       len = 16;
      3:       len = 24;
      4:       len = 32;
      default: len = $urandom_range(32);
    endcase
    if (len == 0) return '0;
    return ~32'h0 << (32 - len);
  endfunction

  // Most addresses fall in a few narrow ranges so that routes overlap.
  function automatic logic [ADDR_W-1:0] random_addr();
    if ($urandom_range(99) < 30) return $urandom;
    return {8'h0A, 6'h00, 2'($urandom_range(3)), 16'($urandom)};
  endfunction

  function automatic logic [COST_W-1:0] random_metric();
    if ($urandom_range(99) < 50) return COST_W'($urandom_range(3));
    return COST_W'($urandom);
  endfunction

  task automatic run_random(int count);
    int                r, j;
    logic [ADDR_W-1:0] m, a;
    for (int k = 0; k < count; k++) begin
      r = $urandom_range(99);
      j = sb.any_route();
      if (r < 33) begin
        if (j >= 0 && $urandom_range(99) < 15) begin
          send_cmd(CMD_ADD, sb.routes[j].dest, sb.routes[j].mask, sb.routes[j].port,
                   random_metric());
        end else begin
          m = random_mask();
          a = random_addr();
          if ($urandom_range(99) < 90) a &= m;
          send_cmd(CMD_ADD, a, m, PORT_W'($urandom), random_metric());
        end
      end else if (r < 60) begin
        if (j >= 0 && $urandom_range(99) < 75)
          send_cmd(CMD_DEL, sb.routes[j].dest, sb.routes[j].mask, sb.routes[j].port,
                   COST_W'($urandom));
        else if (j >= 0 && $urandom_range(1) == 1)
          send_cmd(CMD_DEL, sb.routes[j].dest, sb.routes[j].mask,
                   sb.routes[j].port ^ PORT_W'($urandom_range(1, 15)), COST_W'($urandom));
        else
          send_cmd(CMD_DEL, random_addr(), random_mask(), PORT_W'($urandom),
                   COST_W'($urandom));
      end else if (r < 95) begin
        r = $urandom_range(99);
        if (j >= 0 && r < 60)
          a = sb.routes[j].dest | (ADDR_W'($urandom) & ~sb.routes[j].mask);
        else if (r < 85)
          a = random_addr();
        else
          a = $urandom;
        send_cmd(CMD_LOOKUP, a, $urandom, PORT_W'($urandom), COST_W'($urandom));
      end else begin
        send_cmd(CMD_UNUSED, $urandom, $urandom, PORT_W'($urandom), COST_W'($urandom));
      end
    end
  endtask

  initial begin : main_seq
    int fill;
    fill = 0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Empty table, default route, host route, duplicates and ties.
    send_cmd(CMD_LOOKUP, 32'h0, 32'h0, 4'h0, 16'h0);
    send_cmd(CMD_DEL, 32'h0, 32'h0, 4'h0, 16'h0);
    send_cmd(CMD_ADD, 32'h0, 32'h0, 4'h0, 16'hFFFF);
    send_cmd(CMD_ADD, 32'h0, 32'h0, 4'h0, 16'h1234);
    send_cmd(CMD_ADD, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 4'hF, 16'h0);
    send_cmd(CMD_LOOKUP, 32'hFFFF_FFFF, 32'h0, 4'h0, 16'h0);
    send_cmd(CMD_LOOKUP, 32'h1234_5678, 32'hFFFF_FFFF, 4'hF, 16'hFFFF);
    send_cmd(CMD_ADD, 32'h0A00_0000, 32'hFF00_0000, 4'h3, 16'd10);
    send_cmd(CMD_ADD, 32'h0A00_0000, 32'hFF00_0000, 4'h4, 16'd10);
    send_cmd(CMD_LOOKUP, 32'h0A01_0203, 32'h0, 4'h0, 16'h0);
    // Destination bits outside the mask make a route that never matches.
    send_cmd(CMD_ADD, 32'h0A00_00FF, 32'hFF00_0000, 4'h5, 16'd0);
    send_cmd(CMD_LOOKUP, 32'h0A00_00FF, 32'h0, 4'h0, 16'h0);
    send_cmd(CMD_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 4'hF, 16'hFFFF);
    send_cmd(CMD_DEL, 32'h0A00_0000, 32'hFF00_0000, 4'h4, 16'h0);
    send_cmd(CMD_DEL, 32'h0A00_0000, 32'hFF00_0000, 4'h4, 16'h0);
    send_cmd(CMD_LOOKUP, 32'h0A01_0203, 32'h0, 4'h0, 16'h0);
    while (sb.route_count() < ENTRIES) begin
      send_cmd(CMD_ADD, {8'hC0, 8'hA8, 8'(fill), 8'h00}, 32'hFFFF_FF00, PORT_W'(fill),
               COST_W'(fill));
      fill++;
    end
    // On a full table the duplicate check still wins over the full check.
    send_cmd(CMD_ADD, 32'h0102_0304, 32'hFFFF_FFFF, 4'h2, 16'd7);
    send_cmd(CMD_ADD, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 4'hF, 16'd9);
    send_cmd(CMD_DEL, 32'h0, 32'h0, 4'h0, 16'h0);
    send_cmd(CMD_ADD, 32'h0102_0304, 32'hFFFF_FFFF, 4'h2, 16'd7);
    send_cmd(CMD_LOOKUP, 32'h0102_0304, 32'h0, 4'h0, 16'h0);
    drain_results();

    // No idling, but the result side holds off long enough to back up the block.
    hold_cycles = 400;
    run_random(PHASE_COMMANDS);
    drain_results();

    send_idle_pct  = 83;
    recv_stall_pct = 0;
    run_random(PHASE_COMMANDS);
    drain_results();

    send_idle_pct  = 0;
    recv_stall_pct = 83;
    run_random(PHASE_COMMANDS);
    drain_results();

    send_idle_pct  = 16;
    recv_stall_pct = 16;
    run_random(PHASE_COMMANDS);
    drain_results();

    repeat (2 * ENTRIES + 16) @(posedge clk_i);

    $display("Run covered %0d commands: %0d adds, %0d duplicates, %0d full refusals,",
             commands_sent, sb.adds, sb.dups, sb.fulls);
    $display("%0d deletes, %0d delete misses, %0d lookup hits, %0d no-route, %0d unused codes",
             sb.deletes, sb.del_misses, sb.hits, sb.misses, sb.unused);
    if (sb.errors == 0 && sb.expected_q.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("%0d mismatches, %0d results still pending", sb.errors,
               sb.expected_q.size());
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
